// ===== hw/rtl/gpb_pkg.sv =====
// Shared types, request codes and bank geometry for the GPIO port register bank.
package gpb_pkg;

   // Bank geometry.
   localparam int MAIN_BANKS        = 9;
   localparam int LOW_POWER_BANK_ID = 11;
   localparam int BANK_SLOTS        = MAIN_BANKS + 1;
   localparam int SLOT_W            = $clog2(BANK_SLOTS);
   localparam int LINES             = 32;
   localparam int FSEL_W            = 4;
   localparam int FSEL_ROW_W        = LINES * FSEL_W;

   // Field widths.
   localparam int KIND_W  = 3;
   localparam int PIN_W   = 9;
   localparam int VALUE_W = 4;
   localparam int BANK_W  = 4;
   localparam int LINE_W  = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_FSEL_RD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FSEL_WR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DATA_RD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA_WR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PULL_WR = 3'd4;

   // Status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_BANK = 1'b1;

   // One request transaction.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [PIN_W-1:0]   pin;
      logic [VALUE_W-1:0] value;
   } gpb_req_type;

   // One response transaction.
   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               status;
   } gpb_rsp_type;

endpackage

// ===== hw/rtl/gpb_store.sv =====
// Per-bank function-select and data storage with request decode and update.
module gpb_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 write_en,
   input  gpb_pkg::gpb_req_type req,
   output gpb_pkg::gpb_rsp_type rsp
);

   logic [gpb_pkg::BANK_W-1:0]     bank;
   logic [gpb_pkg::LINE_W-1:0]     line;
   logic                           is_low_power;
   logic                           present;
   logic [gpb_pkg::SLOT_W-1:0]     slot;
   logic [gpb_pkg::FSEL_ROW_W-1:0] fsel_row;
   logic [gpb_pkg::FSEL_ROW_W-1:0] fsel_row_in;
   logic [gpb_pkg::LINES-1:0]      data_row;
   logic [gpb_pkg::LINES-1:0]      data_row_in;
   logic                           fsel_we;
   logic                           data_we;

   // One row per bank slot: 32 function-select nibbles and 32 data bits.
   logic [gpb_pkg::FSEL_ROW_W-1:0] fsel_ff [gpb_pkg::BANK_SLOTS];
   logic [gpb_pkg::LINES-1:0]      data_ff [gpb_pkg::BANK_SLOTS];

   // Split the global pin into bank and line, then map the bank to a slot.
   assign bank         = req.pin[gpb_pkg::PIN_W-1:gpb_pkg::LINE_W];
   assign line         = req.pin[gpb_pkg::LINE_W-1:0];
   assign is_low_power = (bank == gpb_pkg::BANK_W'(gpb_pkg::LOW_POWER_BANK_ID));
   assign present      = is_low_power || (bank < gpb_pkg::BANK_W'(gpb_pkg::MAIN_BANKS));
   assign slot         = is_low_power ? gpb_pkg::SLOT_W'(gpb_pkg::MAIN_BANKS)
                                      : bank[gpb_pkg::SLOT_W-1:0];

   // Read the addressed rows and build their updated images.
   always_comb begin
      fsel_row    = fsel_ff[slot];
      data_row    = data_ff[slot];
      fsel_row_in = fsel_row;
      fsel_row_in[{line, 2'b00} +: gpb_pkg::FSEL_W] = req.value;
      data_row_in = data_row;
      data_row_in[line] = req.value[0];
   end

   // Decode the request kind into a response and write enables.
   always_comb begin
      rsp.read_value = '0;
      rsp.status     = gpb_pkg::STATUS_OK;
      fsel_we        = 1'b0;
      data_we        = 1'b0;
      if (!present) begin
         rsp.status = gpb_pkg::STATUS_NO_BANK;
      end else begin
         unique case (req.kind)
            gpb_pkg::KIND_FSEL_RD: begin
               rsp.read_value = fsel_row[{line, 2'b00} +: gpb_pkg::FSEL_W];
            end
            gpb_pkg::KIND_FSEL_WR: begin
               fsel_we = 1'b1;
            end
            gpb_pkg::KIND_DATA_RD: begin
               rsp.read_value = {{(gpb_pkg::VALUE_W-1){1'b0}}, data_row[line]};
            end
            gpb_pkg::KIND_DATA_WR: begin
               data_we = 1'b1;
            end
            // The pull field has no readback path, so a pull write only
            // completes with an OK status.
            gpb_pkg::KIND_PULL_WR: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Storage update, one row per transaction; reset clears every row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpb_pkg::BANK_SLOTS; i++) begin
            fsel_ff[i] <= '0;
            data_ff[i] <= '0;
         end
      end else if (write_en) begin
         if (fsel_we) begin
            fsel_ff[slot] <= fsel_row_in;
         end
         if (data_we) begin
            data_ff[slot] <= data_row_in;
         end
      end
   end

   // A function-select write lands in the addressed nibble.
   assert property (@(posedge clock) disable iff (reset)
      write_en && fsel_we |=>
      fsel_ff[$past(slot)][{$past(line), 2'b00} +: gpb_pkg::FSEL_W] == $past(req.value))
      else $error("function-select write not stored");

   // A data write lands in the addressed bit.
   assert property (@(posedge clock) disable iff (reset)
      write_en && data_we |=> data_ff[$past(slot)][$past(line)] == $past(req.value[0]))
      else $error("data write not stored");

   // An absent bank never enables a write and never reads back a value.
   assert property (@(posedge clock) disable iff (reset)
      !present |-> !fsel_we && !data_we && rsp.read_value == '0)
      else $error("absent bank produced an access");

endmodule

// ===== hw/rtl/gpio_port_register_bank_top.sv =====
// Top level of the GPIO port register bank: request register, storage and response register.
// A request is held in the request register, then its result in the response register.
// One transaction per cycle unless stalled; each is one read-modify-write of a bank row.
// The request register frees up whenever the response register is empty or being taken.
// Reset: synchronous; clears every function-select and data bit to zero and empties
// both the request and the response register.
module gpio_port_register_bank_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gpb_pkg::KIND_W-1:0]  req_type,
   input  logic [gpb_pkg::PIN_W-1:0]   req_pin,
   input  logic [gpb_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gpb_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                        rsp_status
);

   logic                 req_valid_ff;
   gpb_pkg::gpb_req_type req_ff;
   logic                 rsp_valid_ff;
   gpb_pkg::gpb_rsp_type rsp_ff;
   gpb_pkg::gpb_rsp_type rsp_in;
   logic                 advance;

   // The held request moves on when the response register can take it.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.kind  <= req_type;
         req_ff.pin   <= req_pin;
         req_ff.value <= req_value;
      end
   end

   // Storage and decode for the held request.
   gpb_store u_store (
      .clock    (clock),
      .reset    (reset),
      .write_en (advance),
      .req      (req_ff),
      .rsp      (rsp_in)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_status     = rsp_ff.status;

   // A transaction never overwrites a response that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("response overwritten while stalled");

   // A stalled response keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled response changed");

   // A request that moves on always produces a response.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("request moved on without a response");

endmodule
